// File: sv/direct_mapped_cache_tag_check_unit_defines.svh
// Assertion macros shared by the cache tag check unit.
`ifndef DIRECT_MAPPED_CACHE_TAG_CHECK_UNIT_DEFINES_SVH
`define DIRECT_MAPPED_CACHE_TAG_CHECK_UNIT_DEFINES_SVH

// The antecedent implies the consequent in the same cycle.
`define DMC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define DMC_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/dmc_pkg.sv
package dmc_pkg;

   localparam int MAX_LINES_DEF = 1024;
   localparam int ADDR_BITS_DEF = 32;

   localparam int LB_W       = 17;
   localparam int LC_W       = 11;
   localparam int TAG_W      = 32;
   localparam int CNT_W      = 32;
   localparam int IDX_OUT_W  = 10;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   localparam logic [LB_W-1:0] LB_RESET = LB_W'(16);
   localparam logic [LC_W-1:0] LC_RESET = LC_W'(1024);

   localparam logic [CSR_IDX_W-1:0] CSR_LINE_BYTES = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_COUNT = CSR_IDX_W'(1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV_BLOCK,
      ST_DIV_LINE,
      ST_READ,
      ST_LOOKUP
   } dmc_state_type;

   typedef struct packed {
      logic div_start;
      logic div_second;
      logic capture;
      logic rd_en;
      logic commit;
      logic clr_step;
   } dmc_cmd_type;

   typedef struct packed {
      logic div_done;
      logic clr_last;
   } dmc_sts_type;

endpackage

// File: sv/direct_mapped_cache_tag_check_unit.sv
// Each transaction runs the shared one-bit-a-cycle divider twice, then a tag read and a
// lookup that writes the tag on a miss; busy stays high, so a new transaction is accepted
// only after the last one has committed.
// Reset: synchronous; counters clear, line size and count return to 16 and 1024, and a
// clearing pass over every line zeroes the valid bits while busy stays high.
// The receiver cannot stall: each result is presented for exactly one cycle.
module direct_mapped_cache_tag_check_unit #(
   parameter int MAX_LINES = dmc_pkg::MAX_LINES_DEF,
   parameter int ADDR_BITS = dmc_pkg::ADDR_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [ADDR_BITS-1:0]            req_address,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [dmc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dmc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output logic                            rsp_valid,
   output logic                            rsp_hit,
   output logic [dmc_pkg::IDX_OUT_W-1:0]   rsp_line_index,
   output logic [dmc_pkg::TAG_W-1:0]       rsp_access_tag,
   output logic                            rsp_was_valid,
   output logic [dmc_pkg::TAG_W-1:0]       rsp_old_tag,
   output logic [dmc_pkg::CNT_W-1:0]       rsp_access_count,
   output logic [dmc_pkg::CNT_W-1:0]       rsp_hit_count,
   output logic [dmc_pkg::CNT_W-1:0]       rsp_miss_count
);

   import dmc_pkg::*;

   dmc_cmd_type cmd;
   dmc_sts_type sts;

   assign csr_ready = !busy;

   dmc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   dmc_dpath #(
      .MAX_LINES (MAX_LINES),
      .ADDR_BITS (ADDR_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_address      (req_address),
      .csr_we           (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_hit          (rsp_hit),
      .rsp_line_index   (rsp_line_index),
      .rsp_access_tag   (rsp_access_tag),
      .rsp_was_valid    (rsp_was_valid),
      .rsp_old_tag      (rsp_old_tag),
      .rsp_access_count (rsp_access_count),
      .rsp_hit_count    (rsp_hit_count),
      .rsp_miss_count   (rsp_miss_count)
   );

endmodule

// File: sv/dmc_ram.sv
module dmc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/dmc_div.sv
module dmc_div #(
   parameter int N = 32,
   parameter int M = 17
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [N-1:0] dividend,
   input  logic [M-1:0] divisor,
   output logic         done,
   output logic [N-1:0] quotient,
   output logic [M-1:0] remainder
);

   localparam int CW = (N > 1) ? $clog2(N) : 1;

   logic          run_ff;
   logic          done_ff;
   logic [CW-1:0] cnt_ff;
   logic [N-1:0]  quot_ff;
   logic [M-1:0]  rem_ff;
   logic [M-1:0]  dsr_ff;
   logic [M:0]    shifted;
   logic [M:0]    diff;

   assign shifted = {rem_ff, quot_ff[N-1]};
   assign diff    = shifted - {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + CW'(1);
            if (cnt_ff == CW'(N - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= dividend;
         rem_ff  <= '0;
         dsr_ff  <= divisor;
      end else if (run_ff) begin
         if (!diff[M]) begin
            rem_ff  <= diff[M-1:0];
            quot_ff <= {quot_ff[N-2:0], 1'b1};
         end else begin
            rem_ff  <= shifted[M-1:0];
            quot_ff <= {quot_ff[N-2:0], 1'b0};
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

// File: sv/dmc_ctrl.sv
`include "direct_mapped_cache_tag_check_unit_defines.svh"

module dmc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  dmc_pkg::dmc_sts_type sts,
   output dmc_pkg::dmc_cmd_type cmd
);

   import dmc_pkg::*;

   dmc_state_type state_ff;
   dmc_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV_BLOCK;
            end
         end
         ST_DIV_BLOCK: begin
            if (sts.div_done) begin
               cmd.div_start  = 1'b1;
               cmd.div_second = 1'b1;
               state_in       = ST_DIV_LINE;
            end
         end
         ST_DIV_LINE: begin
            cmd.div_second = 1'b1;
            if (sts.div_done) begin
               cmd.capture = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            cmd.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   `DMC_ASSERT_NXT(a_start_busy, start && !busy, busy, "accepted transaction did not raise busy")
   `DMC_ASSERT_NXT(a_commit_idle, cmd.commit, !busy && !cmd.commit, "no return to idle after lookup")

endmodule

// File: sv/dmc_dpath.sv
`include "direct_mapped_cache_tag_check_unit_defines.svh"

module dmc_dpath #(
   parameter int MAX_LINES = dmc_pkg::MAX_LINES_DEF,
   parameter int ADDR_BITS = dmc_pkg::ADDR_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [ADDR_BITS-1:0]            req_address,
   input  logic                            csr_we,
   input  logic [dmc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dmc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  dmc_pkg::dmc_cmd_type            cmd,
   output dmc_pkg::dmc_sts_type            sts,
   output logic                            rsp_valid,
   output logic                            rsp_hit,
   output logic [dmc_pkg::IDX_OUT_W-1:0]   rsp_line_index,
   output logic [dmc_pkg::TAG_W-1:0]       rsp_access_tag,
   output logic                            rsp_was_valid,
   output logic [dmc_pkg::TAG_W-1:0]       rsp_old_tag,
   output logic [dmc_pkg::CNT_W-1:0]       rsp_access_count,
   output logic [dmc_pkg::CNT_W-1:0]       rsp_hit_count,
   output logic [dmc_pkg::CNT_W-1:0]       rsp_miss_count
);

   import dmc_pkg::*;

   localparam int AW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   logic [LB_W-1:0]      lb_ff;
   logic [LC_W-1:0]      lc_ff;
   logic [LB_W-1:0]      bytes_eff;
   logic [LB_W-1:0]      lc_ext;
   logic [LB_W-1:0]      lines_eff;
   logic [ADDR_BITS-1:0] div_dividend;
   logic [LB_W-1:0]      div_divisor;
   logic                 div_done;
   logic [ADDR_BITS-1:0] div_quot;
   logic [LB_W-1:0]      div_rem;
   logic [63:0]          quot_ext;
   logic [AW-1:0]        idx_ff;
   logic [TAG_W-1:0]     tag_ff;
   logic [31:0]          idx_ext;
   logic [AW-1:0]        clr_cnt_ff;
   logic [AW-1:0]        wr_addr;
   logic                 vld_we;
   logic                 tag_we;
   logic [0:0]           vld_rd;
   logic [TAG_W-1:0]     tag_rd;
   logic                 was_valid;
   logic                 is_hit;
   logic [TAG_W-1:0]     prev_tag;
   logic [CNT_W-1:0]     acc_ff;
   logic [CNT_W-1:0]     hits_ff;
   logic [CNT_W-1:0]     miss_ff;
   logic [CNT_W-1:0]     acc_in;
   logic [CNT_W-1:0]     hits_in;
   logic [CNT_W-1:0]     miss_in;
   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic [IDX_OUT_W-1:0] rsp_line_index_ff;
   logic [TAG_W-1:0]     rsp_access_tag_ff;
   logic                 rsp_was_valid_ff;
   logic [TAG_W-1:0]     rsp_old_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lb_ff <= LB_RESET;
         lc_ff <= LC_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_LINE_BYTES) begin
            lb_ff <= csr_wdata[LB_W-1:0];
         end else if (csr_index == CSR_LINE_COUNT) begin
            lc_ff <= csr_wdata[LC_W-1:0];
         end
      end
   end

   assign bytes_eff = (lb_ff == '0) ? LB_W'(1) : lb_ff;
   assign lc_ext    = LB_W'(lc_ff);

   always_comb begin
      priority if (lc_ff == '0) begin
         lines_eff = LB_W'(1);
      end else if (lc_ext > LB_W'(MAX_LINES)) begin
         lines_eff = LB_W'(MAX_LINES);
      end else begin
         lines_eff = lc_ext;
      end
   end

   assign div_dividend = cmd.div_second ? div_quot : req_address;
   assign div_divisor  = cmd.div_second ? lines_eff : bytes_eff;

   dmc_div #(
      .N (ADDR_BITS),
      .M (LB_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   assign quot_ext = 64'(div_quot);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         idx_ff <= div_rem[AW-1:0];
         tag_ff <= quot_ext[TAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_cnt_ff <= clr_cnt_ff + AW'(1);
      end
   end

   assign wr_addr = cmd.clr_step ? clr_cnt_ff : idx_ff;
   assign vld_we  = cmd.clr_step || (cmd.commit && !is_hit);
   assign tag_we  = cmd.commit && !is_hit;

   dmc_ram #(
      .WIDTH (1),
      .DEPTH (MAX_LINES)
   ) u_valid_ram (
      .clock   (clock),
      .wr_en   (vld_we),
      .wr_addr (wr_addr),
      .wr_data (~cmd.clr_step),
      .rd_en   (cmd.rd_en),
      .rd_addr (idx_ff),
      .rd_data (vld_rd)
   );

   dmc_ram #(
      .WIDTH (TAG_W),
      .DEPTH (MAX_LINES)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_we),
      .wr_addr (idx_ff),
      .wr_data (tag_ff),
      .rd_en   (cmd.rd_en),
      .rd_addr (idx_ff),
      .rd_data (tag_rd)
   );

   assign was_valid = vld_rd[0];
   assign prev_tag  = was_valid ? tag_rd : '0;
   assign is_hit    = was_valid && (tag_rd == tag_ff);

   assign acc_in  = (acc_ff == CNT_MAX) ? acc_ff : acc_ff + CNT_W'(1);
   assign hits_in = (is_hit && (hits_ff != CNT_MAX)) ? hits_ff + CNT_W'(1) : hits_ff;
   assign miss_in = (!is_hit && (miss_ff != CNT_MAX)) ? miss_ff + CNT_W'(1) : miss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         hits_ff      <= '0;
         miss_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.commit;
         if (cmd.commit) begin
            acc_ff  <= acc_in;
            hits_ff <= hits_in;
            miss_ff <= miss_in;
         end
      end
   end

   assign idx_ext = 32'(idx_ff);

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit_ff        <= is_hit;
         rsp_line_index_ff <= idx_ext[IDX_OUT_W-1:0];
         rsp_access_tag_ff <= tag_ff;
         rsp_was_valid_ff  <= was_valid;
         rsp_old_tag_ff    <= prev_tag;
      end
   end

   assign sts.div_done = div_done;
   assign sts.clr_last = (clr_cnt_ff == AW'(MAX_LINES - 1));

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_line_index   = rsp_line_index_ff;
   assign rsp_access_tag   = rsp_access_tag_ff;
   assign rsp_was_valid    = rsp_was_valid_ff;
   assign rsp_old_tag      = rsp_old_tag_ff;
   assign rsp_access_count = acc_ff;
   assign rsp_hit_count    = hits_ff;
   assign rsp_miss_count   = miss_ff;

   `DMC_ASSERT_IMP(a_hit_needs_valid, rsp_valid && rsp_hit, rsp_was_valid, "hit on an invalid line")
   `DMC_ASSERT_IMP(a_invalid_old_tag, rsp_valid && !rsp_was_valid, rsp_old_tag == '0, "old tag of an invalid line is not zero")
   `DMC_ASSERT_IMP(a_hit_tag_match, rsp_valid && rsp_hit, rsp_old_tag == rsp_access_tag, "hit with mismatched tag")

endmodule
